// ===== sv/egi_pkg.sv =====
// ----------------------------------------------------------------------------
// egi_pkg
// Shared types, codes and constants of the EMG gesture interpreter.
// ----------------------------------------------------------------------------
package egi_pkg;

  localparam int unsigned CHANNELS = 3;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned COOL_W   = 15;
  localparam int unsigned SAMPLES_W = 16;
  localparam int unsigned DELAY_W  = 16;

  // window and classification limits
  localparam logic [TIME_W-1:0]    MIN_WINDOW_MS = 32'd80;
  localparam logic [SAMPLES_W-1:0] SAMPLE_CAP    = 16'd65530;
  localparam logic [SAMPLE_W-1:0]  TWO_CH_MARGIN = 12'd240;
  localparam logic [SAMPLE_W-1:0]  ONE_CH_FLOOR  = 12'd1650;
  localparam logic [SAMPLE_W-1:0]  ONE_CH_STRONG = 12'd2500;
  localparam logic [TIME_W-1:0]    ONE_CH_LONG   = 32'd360;
  localparam logic [TIME_W-1:0]    ONE_CH_MID    = 32'd270;
  localparam logic [COUNT_W-1:0]   COUNT_CAP     = 3'd5;
  localparam logic [COOL_W-1:0]    COOL_CAP      = 15'd32767;
  localparam logic [9:0]           MS_PER_SEC    = 10'd1000;

  // configuration register indexes
  localparam logic [2:0] REG_CHANNEL_COUNT  = 3'd0;
  localparam logic [2:0] REG_DIRECTIONAL    = 3'd1;
  localparam logic [2:0] REG_BEND_NEEDED    = 3'd2;
  localparam logic [2:0] REG_UNFOLD_NEEDED  = 3'd3;
  localparam logic [2:0] REG_SWITCH_DELAY   = 3'd4;
  localparam logic [2:0] REG_THRESHOLD      = 3'd5;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_BEND   = 2'd1,
    EV_UNFOLD = 2'd2,
    EV_OTHER  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_BENT     = 2'd1,
    ACT_EXTENDED = 2'd2,
    ACT_IGNORED  = 2'd3
  } action_t;

  // stored activity window of one pair, as seen by the classifier
  typedef struct packed {
    logic [TIME_W-1:0]    start_ms;
    logic [TIME_W-1:0]    last_ms;
    logic [SAMPLES_W-1:0] samples;
    logic [SAMPLE_W-1:0]  peak0;
    logic [SAMPLE_W-1:0]  peak1;
    logic [SAMPLE_W-1:0]  peak2;
  } win_t;

endpackage

// ===== sv/egi_lane.sv =====
// ----------------------------------------------------------------------------
// egi_lane
// One EMG channel: masks the incoming sample and tracks the channel peak.
// ----------------------------------------------------------------------------
module egi_lane (
  input  logic [egi_pkg::SAMPLE_W-1:0] sample,
  input  logic                         sample_ok,
  output logic [egi_pkg::SAMPLE_W-1:0] level,
  input  logic [egi_pkg::SAMPLE_W-1:0] level_q,
  input  logic [egi_pkg::SAMPLE_W-1:0] peak,
  input  logic                         fresh,
  output logic [egi_pkg::SAMPLE_W-1:0] peak_next
);

  logic [egi_pkg::SAMPLE_W-1:0] base;

  // unused or invalid channel contributes a zero level
  assign level = sample_ok ? sample : '0;

  // a fresh window starts its peak from zero
  assign base      = fresh ? '0 : peak;
  assign peak_next = (level_q > base) ? level_q : base;

endmodule

// ===== sv/egi_merge.sv =====
// ----------------------------------------------------------------------------
// egi_merge
// Combines the lane levels: largest level and the activity decision.
// ----------------------------------------------------------------------------
module egi_merge (
  input  logic [egi_pkg::SAMPLE_W-1:0] level0,
  input  logic [egi_pkg::SAMPLE_W-1:0] level1,
  input  logic [egi_pkg::SAMPLE_W-1:0] level2,
  input  logic [egi_pkg::SAMPLE_W-1:0] threshold,
  output logic                         active
);

  logic [egi_pkg::SAMPLE_W-1:0] max01;
  logic [egi_pkg::SAMPLE_W-1:0] max012;

  assign max01  = (level1 > level0) ? level1 : level0;
  assign max012 = (level2 > max01) ? level2 : max01;
  assign active = (max012 >= threshold);

endmodule

// ===== sv/egi_classify.sv =====
// ----------------------------------------------------------------------------
// egi_classify
// Classifies a finished activity window and maps the class to an event.
// ----------------------------------------------------------------------------
module egi_classify (
  input  egi_pkg::win_t  win,
  input  logic [1:0]     chans,
  input  logic           directional,
  output egi_pkg::event_t ev
);

  // window classes
  localparam logic [1:0] CLS_IDLE   = 2'd0;
  localparam logic [1:0] CLS_BEND   = 2'd1;
  localparam logic [1:0] CLS_UNFOLD = 2'd2;
  localparam logic [1:0] CLS_OTHER  = 2'd3;

  logic [egi_pkg::TIME_W-1:0]   dur;
  logic [egi_pkg::SAMPLE_W-1:0] diff;
  logic                         long_enough;
  logic [1:0]                   cls;

  assign dur         = win.last_ms - win.start_ms + 32'd1;
  assign long_enough = (dur >= egi_pkg::MIN_WINDOW_MS);
  assign diff        = (win.peak0 > win.peak1) ? (win.peak0 - win.peak1)
                                               : (win.peak1 - win.peak0);

  // class from peaks and duration, by channel count
  always_comb begin
    cls = CLS_IDLE;
    if (chans == 2'd0 || win.samples == '0) begin
      cls = CLS_IDLE;
    end else if (chans == 2'd3) begin
      if (win.peak0 >= win.peak1 && win.peak0 >= win.peak2) begin
        cls = CLS_BEND;
      end else if (win.peak1 >= win.peak0 && win.peak1 >= win.peak2) begin
        cls = CLS_UNFOLD;
      end else begin
        cls = CLS_OTHER;
      end
    end else if (chans == 2'd2) begin
      if (diff < egi_pkg::TWO_CH_MARGIN) begin
        cls = CLS_OTHER;
      end else if (win.peak0 > win.peak1) begin
        cls = CLS_BEND;
      end else begin
        cls = CLS_UNFOLD;
      end
    end else begin
      if (win.peak0 < egi_pkg::ONE_CH_FLOOR) begin
        cls = CLS_IDLE;
      end else if (dur >= egi_pkg::ONE_CH_LONG) begin
        cls = CLS_UNFOLD;
      end else if (win.peak0 < egi_pkg::ONE_CH_STRONG || dur >= egi_pkg::ONE_CH_MID) begin
        cls = CLS_OTHER;
      end else begin
        cls = CLS_BEND;
      end
    end
  end

  // class to event; unfold counts as bend in counted mode
  always_comb begin
    ev = egi_pkg::EV_NONE;
    if (long_enough) begin
      case (cls)
        CLS_BEND:   ev = egi_pkg::EV_BEND;
        CLS_UNFOLD: ev = directional ? egi_pkg::EV_UNFOLD : egi_pkg::EV_BEND;
        CLS_OTHER:  ev = egi_pkg::EV_OTHER;
        default:    ev = egi_pkg::EV_NONE;
      endcase
    end
  end

endmodule

// ===== sv/emg_gesture_interpreter.sv =====
// ----------------------------------------------------------------------------
// emg_gesture_interpreter
// Per-pair EMG activity windows, gesture classification and finger control.
// ----------------------------------------------------------------------------
// Each sample set passes two register stages: the first masks the three
// channel lanes and decides activity, the second reads and rewrites the
// pair's window and finger state, so a new transaction is taken every
// cycle unless the sink stalls, even for the same pair, and its result
// follows the first stage into the output register. The output register
// holds a result while the sink stalls and the first stage still takes one
// more transaction. The pair index travels in tuser; a pair at or above
// PAIR_COUNT leaves all state alone and returns zeros. Configuration writes
// are always ready and take effect at once; they belong to idle periods.
// ----------------------------------------------------------------------------
module emg_gesture_interpreter #(
  parameter int unsigned PAIR_COUNT = 2
) (
  input  logic        clk,
  input  logic        rst,
  // input sample sets
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // now_ms, sample_ch0, sample_ch1, sample_ch2, valid_mask
  input  logic        s_tuser,   // pair
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // event_res, action, finger_bent, bend_progress,
                                 // unfold_progress, cooldown_ms
  output logic        m_tuser,   // pair_out
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int unsigned PIDX_W = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
  localparam int unsigned SW     = egi_pkg::SAMPLE_W;
  localparam int unsigned TW     = egi_pkg::TIME_W;
  localparam int unsigned CW     = egi_pkg::COUNT_W;

  // configuration registers
  logic [1:0]                  channel_count;
  logic                        directional_mode;
  logic [CW-1:0]               bend_moves_needed;
  logic [CW-1:0]               unfold_moves_needed;
  logic [egi_pkg::DELAY_W-1:0] delay_ms;
  logic [SW-1:0]               active_threshold;

  // per-pair state
  logic                           win_active   [PAIR_COUNT];
  logic [TW-1:0]                  win_start    [PAIR_COUNT];
  logic [TW-1:0]                  win_last     [PAIR_COUNT];
  logic [egi_pkg::SAMPLES_W-1:0]  win_samples  [PAIR_COUNT];
  logic [SW-1:0]                  peak         [PAIR_COUNT][egi_pkg::CHANNELS];
  logic                           bent_state   [PAIR_COUNT];
  logic [CW-1:0]                  bend_count   [PAIR_COUNT];
  logic [CW-1:0]                  unfold_count [PAIR_COUNT];
  logic [TW-1:0]                  cool_until   [PAIR_COUNT];

  // first stage registers
  logic          s1_valid;
  logic          s1_pair;
  logic [TW-1:0] s1_now;
  logic [SW-1:0] s1_level [egi_pkg::CHANNELS];
  logic          s1_active;

  // output register
  logic [31:0] out_data;
  logic        out_pair;

  logic advance;
  logic s1_fire;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count       <= 2'd3;
      directional_mode    <= 1'b0;
      bend_moves_needed   <= 3'd2;
      unfold_moves_needed <= 3'd2;
      delay_ms            <= 16'd1000;
      active_threshold    <= 12'd1500;
    end else if (cfg_valid) begin
      case (cfg_index)
        egi_pkg::REG_CHANNEL_COUNT: channel_count       <= cfg_data[1:0];
        egi_pkg::REG_DIRECTIONAL:   directional_mode    <= cfg_data[0];
        egi_pkg::REG_BEND_NEEDED:   bend_moves_needed   <= cfg_data[2:0];
        egi_pkg::REG_UNFOLD_NEEDED: unfold_moves_needed <= cfg_data[2:0];
        egi_pkg::REG_SWITCH_DELAY:
          delay_ms <= egi_pkg::DELAY_W'(cfg_data[5:0])
                      * egi_pkg::DELAY_W'(egi_pkg::MS_PER_SEC);
        egi_pkg::REG_THRESHOLD:     active_threshold    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign s1_fire  = s1_valid && advance;

  // ---------------------------------------------------------------- lanes
  logic [SW-1:0] in_sample [egi_pkg::CHANNELS];
  logic [SW-1:0] in_level  [egi_pkg::CHANNELS];
  logic [SW-1:0] peak_next [egi_pkg::CHANNELS];
  logic [2:0]    in_mask;
  logic [PIDX_W-1:0] idx;
  logic          pair_ok;
  logic          fresh;

  assign in_sample[0] = s_tdata[43:32];
  assign in_sample[1] = s_tdata[55:44];
  assign in_sample[2] = s_tdata[67:56];
  assign in_mask      = s_tdata[70:68];

  assign idx     = PIDX_W'(s1_pair);
  assign pair_ok = (32'(s1_pair) < PAIR_COUNT);
  assign fresh   = !win_active[idx];

  for (genvar c = 0; c < egi_pkg::CHANNELS; c++) begin : g_lane
    egi_lane u_lane (
      .sample    (in_sample[c]),
      .sample_ok (in_mask[c] && (32'(c) < 32'(channel_count))),
      .level     (in_level[c]),
      .level_q   (s1_level[c]),
      .peak      (peak[idx][c]),
      .fresh     (fresh),
      .peak_next (peak_next[c])
    );
  end

  logic in_active;

  egi_merge u_merge (
    .level0    (in_level[0]),
    .level1    (in_level[1]),
    .level2    (in_level[2]),
    .threshold (active_threshold),
    .active    (in_active)
  );

  // first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      s1_pair   <= s_tuser;
      s1_now    <= s_tdata[31:0];
      s1_level  <= in_level;
      s1_active <= in_active;
    end
  end

  // ---------------------------------------------------------------- classify
  egi_pkg::win_t   cur_win;
  egi_pkg::event_t cls_ev;

  assign cur_win.start_ms = win_start[idx];
  assign cur_win.last_ms  = win_last[idx];
  assign cur_win.samples  = win_samples[idx];
  assign cur_win.peak0    = peak[idx][0];
  assign cur_win.peak1    = peak[idx][1];
  assign cur_win.peak2    = peak[idx][2];

  egi_classify u_classify (
    .win         (cur_win),
    .chans       (channel_count),
    .directional (directional_mode),
    .ev          (cls_ev)
  );

  // ---------------------------------------------------------------- pair update
  egi_pkg::event_t               ev;
  egi_pkg::action_t              act;
  logic                          active_next;
  logic [TW-1:0]                 start_next;
  logic [egi_pkg::SAMPLES_W-1:0] samples_base;
  logic [egi_pkg::SAMPLES_W-1:0] samples_next;
  logic                          bent_next;
  logic [CW-1:0]                 bend_next;
  logic [CW-1:0]                 unfold_next;
  logic [TW-1:0]                 until_next;
  logic [egi_pkg::COOL_W-1:0]    cool;
  logic [TW-1:0]                 cool_diff;
  logic                          in_cool;
  logic [CW-1:0]                 bend_inc;
  logic [CW-1:0]                 unfold_inc;

  // window tracking
  always_comb begin
    active_next  = win_active[idx];
    start_next   = win_start[idx];
    samples_base = fresh ? '0 : win_samples[idx];
    samples_next = win_samples[idx];
    ev           = egi_pkg::EV_NONE;
    if (s1_active) begin
      active_next  = 1'b1;
      start_next   = fresh ? s1_now : win_start[idx];
      samples_next = (samples_base < egi_pkg::SAMPLE_CAP) ? samples_base + 16'd1
                                                          : samples_base;
    end else if (win_active[idx]) begin
      active_next  = 1'b0;
      samples_next = '0;
      ev           = cls_ev;
    end
  end

  // finger control
  assign in_cool    = (s1_now < cool_until[idx]);
  assign cool_diff  = cool_until[idx] - s1_now;
  assign bend_inc   = (bend_count[idx] < egi_pkg::COUNT_CAP) ? bend_count[idx] + 3'd1
                                                             : bend_count[idx];
  assign unfold_inc = (unfold_count[idx] < egi_pkg::COUNT_CAP) ? unfold_count[idx] + 3'd1
                                                               : unfold_count[idx];

  always_comb begin
    bent_next   = bent_state[idx];
    bend_next   = bend_count[idx];
    unfold_next = unfold_count[idx];
    until_next  = cool_until[idx];
    act         = egi_pkg::ACT_NONE;
    if (!in_cool) begin
      cool = '0;
    end else if (cool_diff > TW'(egi_pkg::COOL_CAP)) begin
      cool = egi_pkg::COOL_CAP;
    end else begin
      cool = cool_diff[egi_pkg::COOL_W-1:0];
    end
    if (ev != egi_pkg::EV_NONE) begin
      if (directional_mode) begin
        if (ev == egi_pkg::EV_BEND || ev == egi_pkg::EV_UNFOLD) begin
          bent_next   = (ev == egi_pkg::EV_BEND);
          bend_next   = '0;
          unfold_next = '0;
          act = (ev == egi_pkg::EV_BEND) ? egi_pkg::ACT_BENT : egi_pkg::ACT_EXTENDED;
        end
      end else if (!bent_state[idx]) begin
        if (ev == egi_pkg::EV_BEND) begin
          bend_next = bend_inc;
          if (bend_inc >= bend_moves_needed) begin
            bent_next   = 1'b1;
            bend_next   = '0;
            unfold_next = '0;
            until_next  = s1_now + TW'(delay_ms);
            cool = (delay_ms > egi_pkg::DELAY_W'(egi_pkg::COOL_CAP)) ? egi_pkg::COOL_CAP
                                                   : delay_ms[egi_pkg::COOL_W-1:0];
            act = egi_pkg::ACT_BENT;
          end
        end
      end else if (in_cool) begin
        act = egi_pkg::ACT_IGNORED;
      end else if (ev == egi_pkg::EV_BEND) begin
        unfold_next = unfold_inc;
        if (unfold_inc >= unfold_moves_needed) begin
          bent_next   = 1'b0;
          bend_next   = '0;
          unfold_next = '0;
          act = egi_pkg::ACT_EXTENDED;
        end
      end
    end
  end

  // pair state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PAIR_COUNT; p++) begin
        win_active[p]   <= 1'b0;
        win_start[p]    <= '0;
        win_last[p]     <= '0;
        win_samples[p]  <= '0;
        bent_state[p]   <= 1'b0;
        bend_count[p]   <= '0;
        unfold_count[p] <= '0;
        cool_until[p]   <= '0;
        for (int c = 0; c < egi_pkg::CHANNELS; c++) begin
          peak[p][c] <= '0;
        end
      end
    end else if (s1_fire && pair_ok) begin
      win_active[idx]   <= active_next;
      win_start[idx]    <= start_next;
      win_samples[idx]  <= samples_next;
      bent_state[idx]   <= bent_next;
      bend_count[idx]   <= bend_next;
      unfold_count[idx] <= unfold_next;
      cool_until[idx]   <= until_next;
      if (s1_active) begin
        win_last[idx] <= s1_now;
        peak[idx]     <= peak_next;
      end
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pair <= s1_pair;
      if (pair_ok) begin
        out_data <= {6'd0, cool, unfold_next, bend_next, bent_next, act, ev};
      end else begin
        out_data <= '0;
      end
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = out_pair;

endmodule

// ===== tb/tb_emg_gesture_interpreter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_emg_gesture_interpreter
// Self-checking bench for the EMG gesture interpreter.
// ----------------------------------------------------------------------------
// A short directed table runs first with the reset settings: quiet and
// invalid sets, a window that is too short, two bends that bend the finger,
// a gesture swallowed by the cooldown, a window across the time wrap and one
// at the top of the time range. Eight random phases follow, each with its
// own register settings (extremes included). Most random traffic is built
// from whole gestures (active sets spread over a chosen span, then usually a release
// set) with random levels, so the windows reach classification; the rest is
// noise. Every accepted sample set is run through a local model of the
// windowing, classification and finger logic, and each result transaction
// is checked field by field against the oldest expected report.
// ----------------------------------------------------------------------------
module tb_emg_gesture_interpreter;

  localparam int unsigned PAIRS       = 2;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_SETS  = 178;
  localparam int unsigned STALL_LIMIT = 5000;

  // gesture rules
  localparam logic [31:0] WINDOW_MIN  = 32'd80;
  localparam logic [15:0] SAMPLES_SAT = 16'd65530;
  localparam logic [11:0] MARGIN_2CH  = 12'd240;
  localparam logic [11:0] FLOOR_1CH   = 12'd1650;
  localparam logic [11:0] STRONG_1CH  = 12'd2500;
  localparam logic [31:0] LONG_1CH    = 32'd360;
  localparam logic [31:0] MID_1CH     = 32'd270;
  localparam logic [2:0]  MOVES_SAT   = 3'd5;
  localparam logic [31:0] COOL_SAT    = 32'd32767;

  typedef struct packed {
    logic        pair;
    logic [31:0] now;
    logic [11:0] ch0;
    logic [11:0] ch1;
    logic [11:0] ch2;
    logic [2:0]  mask;
  } emg_set_t;

  typedef struct packed {
    logic             pair;
    egi_pkg::event_t  ev;
    egi_pkg::action_t act;
    logic             bent;
    logic [2:0]       bend_prog;
    logic [2:0]       unfold_prog;
    logic [14:0]      cool;
  } finger_report_t;

  typedef struct packed {
    logic [1:0]  chans;
    logic        dir;
    logic [2:0]  bend_need;
    logic [2:0]  unfold_need;
    logic [5:0]  delay_s;
    logic [11:0] thr;
  } settings_t;

  typedef struct {
    bit             typed;
    emg_set_t       set;
    finger_report_t report;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  // local copy of configuration and per-pair state
  settings_t   live_cfg;
  logic        win_open     [PAIRS];
  logic [31:0] win_start    [PAIRS];
  logic [31:0] win_last     [PAIRS];
  logic [15:0] win_count    [PAIRS];
  logic [11:0] peak         [PAIRS][3];
  logic        bent_now     [PAIRS];
  logic [2:0]  bend_tally   [PAIRS];
  logic [2:0]  unfold_tally [PAIRS];
  logic [31:0] cool_until   [PAIRS];

  finger_report_t expected_reports[$];
  directed_row_t  directed_rows[$];
  int unsigned    mismatches  = 0;
  int unsigned    sets_sent   = 0;
  int unsigned    burst_left  = 0;
  int unsigned    hold_req    = 0;
  int unsigned    idle_cycles = 0;
  logic [31:0]    clock_ms    = '0;

  emg_gesture_interpreter #(.PAIR_COUNT(PAIRS)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // event for a closed window of pair p
  function automatic egi_pkg::event_t gesture_of(input int p);
    logic [11:0]     a, b, c, diff;
    logic [31:0]     span;
    egi_pkg::event_t unfold_ev;
    a = peak[p][0];
    b = peak[p][1];
    c = peak[p][2];
    span = win_last[p] - win_start[p] + 32'd1;
    unfold_ev = live_cfg.dir ? egi_pkg::EV_UNFOLD : egi_pkg::EV_BEND;
    if (live_cfg.chans == 2'd0 || win_count[p] == 16'd0) return egi_pkg::EV_NONE;
    if (live_cfg.chans == 2'd3) begin
      if (a >= b && a >= c) return egi_pkg::EV_BEND;
      if (b >= a && b >= c) return unfold_ev;
      return egi_pkg::EV_OTHER;
    end
    if (live_cfg.chans == 2'd2) begin
      diff = (a > b) ? a - b : b - a;
      if (diff < MARGIN_2CH) return egi_pkg::EV_OTHER;
      return (a > b) ? egi_pkg::EV_BEND : unfold_ev;
    end
    if (a < FLOOR_1CH) return egi_pkg::EV_NONE;
    if (span >= LONG_1CH) return unfold_ev;
    if (a < STRONG_1CH || span >= MID_1CH) return egi_pkg::EV_OTHER;
    return egi_pkg::EV_BEND;
  endfunction

  function automatic finger_report_t interpret_sample(input emg_set_t s);
    finger_report_t   r;
    logic [11:0]      lane [3];
    logic [11:0]      level_max;
    logic [31:0]      cool, delay;
    egi_pkg::event_t  ev;
    egi_pkg::action_t act;
    int               p;
    p = int'(s.pair);
    lane[0] = s.ch0;
    lane[1] = s.ch1;
    lane[2] = s.ch2;
    level_max = '0;
    ev = egi_pkg::EV_NONE;
    act = egi_pkg::ACT_NONE;
    for (int c = 0; c < 3; c++)
      if (c < int'(live_cfg.chans) && s.mask[c] && lane[c] > level_max) level_max = lane[c];

    // activity window tracking
    if (level_max >= live_cfg.thr) begin
      if (!win_open[p]) begin
        win_open[p] = 1'b1;
        win_start[p] = s.now;
        win_count[p] = '0;
        for (int c = 0; c < 3; c++) peak[p][c] = '0;
      end
      win_last[p] = s.now;
      if (win_count[p] < SAMPLES_SAT) win_count[p] = win_count[p] + 16'd1;
      for (int c = 0; c < 3; c++)
        if (c < int'(live_cfg.chans) && s.mask[c] && lane[c] > peak[p][c]) peak[p][c] = lane[c];
    end else if (win_open[p]) begin
      win_open[p] = 1'b0;
      if (win_last[p] - win_start[p] + 32'd1 >= WINDOW_MIN) ev = gesture_of(p);
      win_count[p] = '0;
    end

    cool = (s.now < cool_until[p]) ? cool_until[p] - s.now : 32'd0;

    // finger control
    if (ev != egi_pkg::EV_NONE) begin
      if (live_cfg.dir) begin
        if (ev == egi_pkg::EV_BEND || ev == egi_pkg::EV_UNFOLD) begin
          bent_now[p] = (ev == egi_pkg::EV_BEND);
          bend_tally[p] = '0;
          unfold_tally[p] = '0;
          act = (ev == egi_pkg::EV_BEND) ? egi_pkg::ACT_BENT : egi_pkg::ACT_EXTENDED;
        end
      end else if (!bent_now[p]) begin
        if (ev == egi_pkg::EV_BEND) begin
          if (bend_tally[p] < MOVES_SAT) bend_tally[p] = bend_tally[p] + 3'd1;
          if (bend_tally[p] >= live_cfg.bend_need) begin
            delay = 32'(live_cfg.delay_s) * 32'd1000;
            bent_now[p] = 1'b1;
            bend_tally[p] = '0;
            unfold_tally[p] = '0;
            cool_until[p] = s.now + delay;
            cool = delay;
            act = egi_pkg::ACT_BENT;
          end
        end
      end else if (s.now < cool_until[p]) begin
        act = egi_pkg::ACT_IGNORED;
      end else if (ev == egi_pkg::EV_BEND) begin
        if (unfold_tally[p] < MOVES_SAT) unfold_tally[p] = unfold_tally[p] + 3'd1;
        if (unfold_tally[p] >= live_cfg.unfold_need) begin
          bent_now[p] = 1'b0;
          bend_tally[p] = '0;
          unfold_tally[p] = '0;
          act = egi_pkg::ACT_EXTENDED;
        end
      end
    end

    r.pair = s.pair;
    r.ev = ev;
    r.act = act;
    r.bent = bent_now[p];
    r.bend_prog = bend_tally[p];
    r.unfold_prog = unfold_tally[p];
    r.cool = (cool > COOL_SAT) ? 15'h7fff : cool[14:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // directed row; typed rows expect zero progress counts
  function automatic void row(input bit typed, input logic p, input logic [31:0] t,
                              input logic [11:0] a, input logic [11:0] b,
                              input logic [11:0] c, input logic [2:0] m,
                              input egi_pkg::event_t ev, input egi_pkg::action_t act,
                              input logic bent, input logic [14:0] cool);
    directed_row_t d;
    d.typed = typed;
    d.set = '{pair: p, now: t, ch0: a, ch1: b, ch2: c, mask: m};
    d.report = '{pair: p, ev: ev, act: act, bent: bent, bend_prog: 3'd0,
                 unfold_prog: 3'd0, cool: cool};
    directed_rows.push_back(d);
  endfunction

  function automatic logic [11:0] quiet_level();
    if (live_cfg.thr == 12'd0) return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(0, int'(live_cfg.thr) - 1));
  endfunction

  function automatic logic [11:0] loud_level();
    return 12'($urandom_range(int'(live_cfg.thr), 4095));
  endfunction

  function automatic emg_set_t quiet_set(input logic p, input logic [31:0] t);
    emg_set_t s;
    s.pair = p;
    s.now = t;
    s.ch0 = quiet_level();
    s.ch1 = quiet_level();
    s.ch2 = quiet_level();
    s.mask = 3'($urandom_range(0, 7));
    return s;
  endfunction

  // one in-use channel (channel 0 if none is in use) is valid and at or above the threshold
  function automatic emg_set_t loud_set(input logic p, input logic [31:0] t);
    emg_set_t s;
    int       lead;
    s = quiet_set(p, t);
    lead = $urandom_range(0, (live_cfg.chans == 2'd0) ? 0 : int'(live_cfg.chans) - 1);
    if ($urandom_range(0, 1)) s.ch0 = loud_level();
    if ($urandom_range(0, 1)) s.ch1 = loud_level();
    if ($urandom_range(0, 1)) s.ch2 = loud_level();
    case (lead)
      0: s.ch0 = loud_level();
      1: s.ch1 = loud_level();
      default: s.ch2 = loud_level();
    endcase
    s.mask[lead] = 1'b1;
    return s;
  endfunction

  function automatic emg_set_t noise_set();
    emg_set_t s;
    s.pair = 1'($urandom_range(0, 1));
    s.now = ($urandom_range(0, 3) == 0) ? $urandom() : clock_ms;
    s.ch0 = 12'($urandom_range(0, 4095));
    s.ch1 = 12'($urandom_range(0, 4095));
    s.ch2 = 12'($urandom_range(0, 4095));
    s.mask = 3'($urandom_range(0, 7));
    return s;
  endfunction

  function automatic settings_t phase_settings(input int n);
    settings_t st;
    case (n)
      1: st = '{2'd3, 1'b1, 3'd1, 3'd1, 6'd0,  12'd1500};
      2: st = '{2'd2, 1'b0, 3'd3, 3'd1, 6'd2,  12'd2000};
      3: st = '{2'd1, 1'b0, 3'd1, 3'd2, 6'd0,  12'd1000};
      4: st = '{2'd1, 1'b1, 3'd5, 3'd5, 6'd60, 12'd4095};
      5: st = '{2'd3, 1'b0, 3'd0, 3'd6, 6'd63, 12'd800};
      6: st = '{2'd0, 1'b0, 3'd7, 3'd0, 6'd33, 12'd0};
      7: st = '{2'd2, 1'b1, 3'd4, 3'd3, 6'd10, 12'd300};
      default: begin
        st.chans = 2'($urandom_range(0, 3));
        st.dir = 1'($urandom_range(0, 1));
        st.bend_need = 3'($urandom_range(0, 7));
        st.unfold_need = 3'($urandom_range(0, 7));
        st.delay_s = 6'($urandom_range(0, 63));
        st.thr = 12'($urandom_range(0, 4095));
      end
    endcase
    return st;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // sender works in bursts separated by random gaps
  task automatic send_sample(input emg_set_t s, input bit typed, input finger_report_t rep);
    finger_report_t predicted;
    int unsigned    gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, s.mask, s.ch2, s.ch1, s.ch0, s.now};
    s_tuser <= s.pair;
    do @(posedge clk); while (!s_tready);
    predicted = interpret_sample(s);
    expected_reports.push_back(typed ? rep : predicted);
    sets_sent++;
  endtask

  // active sets over a chosen span, then usually a release set
  task automatic send_gesture(input logic p);
    int unsigned span, steps, offs;
    case ($urandom_range(0, 3))
      0: span = $urandom_range(1, 79);
      1: span = $urandom_range(80, 269);
      2: span = $urandom_range(270, 359);
      default: span = $urandom_range(360, 700);
    endcase
    steps = $urandom_range(2, 6);
    for (int k = 0; k < steps; k++) begin
      offs = (span - 1) * k / (steps - 1);
      send_sample(loud_set(p, clock_ms + offs), 1'b0, '0);
      if ($urandom_range(0, 5) == 0) send_sample(quiet_set(!p, clock_ms + offs), 1'b0, '0);
    end
    clock_ms += span;
    if ($urandom_range(0, 7) != 0) send_sample(quiet_set(p, clock_ms), 1'b0, '0);
    clock_ms += $urandom_range(1, 40);
    // jump far enough to leave most cooldowns behind
    if ($urandom_range(0, 5) == 0) clock_ms += $urandom_range(1000, 70000);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      egi_pkg::REG_CHANNEL_COUNT: live_cfg.chans = val[1:0];
      egi_pkg::REG_DIRECTIONAL:   live_cfg.dir = val[0];
      egi_pkg::REG_BEND_NEEDED:   live_cfg.bend_need = val[2:0];
      egi_pkg::REG_UNFOLD_NEEDED: live_cfg.unfold_need = val[2:0];
      egi_pkg::REG_SWITCH_DELAY:  live_cfg.delay_s = val[5:0];
      egi_pkg::REG_THRESHOLD:     live_cfg.thr = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input settings_t st);
    write_reg(egi_pkg::REG_CHANNEL_COUNT, 12'(st.chans));
    write_reg(egi_pkg::REG_DIRECTIONAL, 12'(st.dir));
    write_reg(egi_pkg::REG_BEND_NEEDED, 12'(st.bend_need));
    write_reg(egi_pkg::REG_UNFOLD_NEEDED, 12'(st.unfold_need));
    write_reg(egi_pkg::REG_SWITCH_DELAY, 12'(st.delay_s));
    write_reg(egi_pkg::REG_THRESHOLD, st.thr);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall pattern in runs, plus long hold-offs on request
  // --------------------------------------------------------------------------
  initial begin
    int unsigned style, run_left, hold_left;
    run_left = 0;
    hold_left = 0;
    style = 0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        style = $urandom_range(0, 3);
        run_left = $urandom_range(20, 200);
      end
      run_left--;
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (style)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (run_left % 5 != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    finger_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t ns: unexpected result transaction, expected none, actual %h/%h",
                 $time, m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("pair_out", want.pair, m_tuser);
        check_field("event_res", want.ev, m_tdata[1:0]);
        check_field("action", want.act, m_tdata[3:2]);
        check_field("finger_bent", want.bent, m_tdata[4]);
        check_field("bend_progress", want.bend_prog, m_tdata[7:5]);
        check_field("unfold_progress", want.unfold_prog, m_tdata[10:8]);
        check_field("cooldown_ms", want.cool, m_tdata[25:11]);
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_end;
    bit          held;
    live_cfg = '{2'd3, 1'b0, 3'd2, 3'd2, 6'd1, 12'd1500};
    for (int p = 0; p < PAIRS; p++) begin
      win_open[p] = 1'b0;
      win_start[p] = '0;
      win_last[p] = '0;
      win_count[p] = '0;
      for (int c = 0; c < 3; c++) peak[p][c] = '0;
      bent_now[p] = 1'b0;
      bend_tally[p] = '0;
      unfold_tally[p] = '0;
      cool_until[p] = '0;
    end

    // reset settings: three channels, counted, two moves, 1 s, threshold 1500
    row(1'b1, 1'b0, 32'd0,   12'd0,    12'd0,    12'd0,    3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b1, 1'b1, 32'd0,   12'd4095, 12'd4095, 12'd4095, 3'b000,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b1, 1'b0, 32'd10,  12'd4095, 12'd0,    12'd0,    3'b001,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b1, 1'b0, 32'd60,  12'd3000, 12'd1000, 12'd2000, 3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    // window under the minimum length gives no event
    row(1'b1, 1'b0, 32'd100, 12'd1499, 12'd1499, 12'd1499, 3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b0, 32'd200, 12'd1500, 12'd0,    12'd0,    3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b0, 32'd290, 12'd4095, 12'd2000, 12'd100,  3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b0, 32'd291, 12'd0,    12'd0,    12'd0,    3'b000,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b0, 32'd300, 12'd2000, 12'd0,    12'd0,    3'b001,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b0, 32'd400, 12'd2500, 12'd0,    12'd0,    3'b001,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    // second bend event bends the finger and opens a one-second cooldown
    row(1'b1, 1'b0, 32'd401, 12'd0,    12'd0,    12'd0,    3'b111,
        egi_pkg::EV_BEND, egi_pkg::ACT_BENT, 1'b1, 15'd1000);
    row(1'b0, 1'b1, 32'd402, 12'd0,    12'd4095, 12'd0,    3'b010,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b1, 32'd500, 12'd0,    12'd3000, 12'd0,    3'b010,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b1, 32'd501, 12'd0,    12'd0,    12'd0,    3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b0, 32'd600, 12'd0,    12'd0,    12'd4095, 3'b100,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b0, 32'd700, 12'd0,    12'd0,    12'd3000, 3'b100,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    // other gesture during the cooldown is ignored
    row(1'b1, 1'b0, 32'd701, 12'd0,    12'd0,    12'd0,    3'b111,
        egi_pkg::EV_OTHER, egi_pkg::ACT_IGNORED, 1'b1, 15'd700);
    row(1'b0, 1'b0, 32'd2000, 12'd4095, 12'd0,   12'd0,    3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b0, 32'd2100, 12'd4095, 12'd100, 12'd100,  3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b0, 32'd2101, 12'd0,    12'd0,   12'd0,    3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    // window across the time wrap; cooldown compare has no wrap handling
    row(1'b0, 1'b0, 32'hffff_ffc0, 12'd4095, 12'd4095, 12'd0, 3'b011,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b0, 32'hffff_ffff, 12'd4095, 12'd0, 12'd0,   3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b0, 32'h0000_0020, 12'd0,  12'd0,    12'd0,    3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b1, 32'hffff_ffff, 12'd4095, 12'd4095, 12'd4095, 3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);
    row(1'b0, 1'b1, 32'hffff_ffff, 12'd0,  12'd0,    12'd0,    3'b111,
        egi_pkg::EV_NONE, egi_pkg::ACT_NONE, 1'b0, 15'd0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_sample(directed_rows[i].set, directed_rows[i].typed, directed_rows[i].report);
    settle_block();

    // random phases, one register setting each
    for (int ph = 1; ph <= PHASES; ph++) begin
      apply_settings(phase_settings(ph));
      clock_ms = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff - $urandom_range(0, 3000)
                                             : $urandom();
      held = 1'b0;
      phase_end = sets_sent + PHASE_SETS;
      while (sets_sent < phase_end) begin
        // long sink hold-off while the sender keeps offering
        if (!held && sets_sent + 120 >= phase_end) begin
          hold_req = $urandom_range(150, 400);
          held = 1'b1;
        end
        if ($urandom_range(0, 7) == 0)
          send_sample(noise_set(), 1'b0, '0);
        else
          send_gesture(1'($urandom_range(0, 1)));
      end
      settle_block();
    end

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
